/* rtl/grsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro rotation step detector package
// Shared widths, register indexes, thresholds and the divider status type.
// ----------------------------------------------------------------------------
package grsd_pkg;

    // Field and register widths.
    localparam int unsigned RATE_W     = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned WSIZE_W    = 7;
    localparam int unsigned BIAS_W     = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    // Default depth of the moving-average window.
    localparam int unsigned WINDOW_MAX_DEF = 64;

    // Arithmetic widths: bias-corrected rate, accumulator, wide product and sum.
    localparam int unsigned ADJ_W   = 17;
    localparam int unsigned ANGLE_W = 40;
    localparam int unsigned WIDE_W  = 50;

    // Detection threshold, 85 degrees in 1/16000 degree units.
    localparam int ANGLE_LIMIT = 1360000;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_BIAS   = 1'b1;

    // Status reported by the iterative divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* rtl/grsd_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro sample channel
// Valid/ready channel carrying one Z rate sample and its timestamp per beat.
// ----------------------------------------------------------------------------
interface grsd_in_if;
    import grsd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [RATE_W-1:0] rate_z;
    logic        [TIME_W-1:0] time_ms;

    modport source (output valid, output rate_z, output time_ms, input ready);
    modport sink   (input valid, input rate_z, input time_ms, output ready);
endinterface

/* rtl/grsd_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation result channel
// Valid/ready channel carrying the direction of a detected quarter turn.
// ----------------------------------------------------------------------------
interface grsd_out_if;
    logic valid;
    logic ready;
    logic rotation_positive;

    modport source (output valid, output rotation_positive, input ready);
    modport sink   (input valid, input rotation_positive, output ready);
endinterface

/* rtl/grsd_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle, for the window average.
// ----------------------------------------------------------------------------
module grsd_div #(
    parameter int unsigned N_W = 22,
    parameter int unsigned D_W = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [N_W-1:0]      i_dividend,
    input  logic [D_W-1:0]      i_divisor,
    output logic [N_W-1:0]      o_quotient,
    output grsd_pkg::t_div_stat o_stat
);
    localparam int unsigned C_W = $clog2(N_W + 1);

    logic [C_W-1:0] r_cnt;
    logic           r_done;
    logic [N_W-1:0] r_quo;
    logic [D_W-1:0] r_rem;
    logic [D_W-1:0] r_div;

    logic [D_W:0]   trial;
    logic [D_W:0]   diff;
    logic           ge;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        trial = {r_rem, r_quo[N_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
    end

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= C_W'(N_W);
                r_quo <= i_dividend;
                r_rem <= '0;
                r_div <= i_divisor;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_quo  <= {r_quo[N_W-2:0], ge};
                r_rem  <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
                r_done <= (r_cnt == C_W'(1));
            end
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
endmodule

/* rtl/gyro_rotation_step_detector_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro rotation step detector
// Averages Z rate samples over a moving window, removes the bias, integrates
// rate times elapsed time into a saturating angle and flags quarter turns.
// ----------------------------------------------------------------------------
// A new sample is taken only in idle, once the previous one has been through
// update, divide, adjust, multiply, sum and check and, for a turn, its result
// beat has been loaded; the iterative divider works one quotient bit per cycle.
// Reset is synchronous: it clears the window, angle and timestamp and sets
// the window size to 1 and the bias to 0; the sample ring is not cleared.
module gyro_rotation_step_detector_unit #(
    parameter int unsigned WINDOW_MAX = grsd_pkg::WINDOW_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    grsd_in_if.sink                           i_in,
    grsd_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [grsd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [grsd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import grsd_pkg::*;

    localparam int unsigned IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int unsigned CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int unsigned SUM_W = RATE_W + $clog2(WINDOW_MAX);
    localparam int unsigned CMP_W = (CNT_W > WSIZE_W) ? CNT_W : WSIZE_W;

    localparam logic [CNT_W-1:0] WMAX_CNT = CNT_W'(WINDOW_MAX);
    localparam logic [CMP_W-1:0] WMAX_CMP = CMP_W'(WINDOW_MAX);
    localparam logic [CNT_W:0]   WMAX_EXT = (CNT_W + 1)'(WINDOW_MAX);
    localparam logic [IDX_W-1:0] PTR_LAST = IDX_W'(WINDOW_MAX - 1);

    localparam logic signed [WIDE_W-1:0] LIM_POS = WIDE_W'(ANGLE_LIMIT);
    localparam logic signed [WIDE_W-1:0] LIM_NEG = -LIM_POS;
    localparam logic signed [WIDE_W-1:0] ACC_MAX =
        {{(WIDE_W - ANGLE_W + 1){1'b0}}, {(ANGLE_W - 1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] ACC_MIN = ~ACC_MAX;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_DIV,
        ST_ADJ,
        ST_MUL,
        ST_SUM,
        ST_CHK
    } t_state;

    t_state                     r_state;
    logic [WSIZE_W-1:0]         r_wsize;
    logic signed [BIAS_W-1:0]   r_bias;
    logic [IDX_W-1:0]           r_ptr;
    logic [CNT_W-1:0]           r_held;
    logic signed [SUM_W-1:0]    r_total;
    logic [TIME_W-1:0]          r_prev;
    logic signed [ANGLE_W-1:0]  r_angle;
    logic                       r_div_start;
    logic                       r_out_valid;
    logic                       r_out_pos;

    logic signed [RATE_W-1:0]   r_sample;
    logic signed [RATE_W-1:0]   r_rd;
    logic [TIME_W-1:0]          r_dt;
    logic                       r_evict;
    logic signed [ADJ_W-1:0]    r_adj;
    logic signed [WIDE_W-1:0]   r_step;
    logic signed [WIDE_W-1:0]   r_sum;

    logic [RATE_W-1:0]          r_ring [WINDOW_MAX];

    logic                       acc_in;
    logic [CMP_W-1:0]           ws_ext;
    logic [CNT_W-1:0]           w_eff;
    logic                       evict;
    logic [CNT_W:0]             old_raw;
    logic [CNT_W:0]             old_wrap;
    logic [IDX_W-1:0]           oldest;
    logic [IDX_W-1:0]           ptr_next;
    logic [SUM_W-1:0]           total_mag;
    logic [SUM_W-1:0]           quotient;
    t_div_stat                  div_stat;
    logic signed [ADJ_W-1:0]    avg_mag;
    logic signed [ADJ_W-1:0]    avg;
    logic signed [TIME_W:0]     dt_s;
    logic signed [WIDE_W-1:0]   mul_p;
    logic                       hit;
    logic signed [WIDE_W-1:0]   sat_v;
    logic                       out_free;

    assign acc_in     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    // Effective window length, clamped to 1..WINDOW_MAX.
    always_comb begin
        ws_ext = CMP_W'(r_wsize);
        if (ws_ext == '0) begin
            w_eff = CNT_W'(1);
        end else if (ws_ext > WMAX_CMP) begin
            w_eff = WMAX_CNT;
        end else begin
            w_eff = CNT_W'(ws_ext);
        end
        evict = (r_held >= w_eff);
    end

    // Ring slot of the oldest held sample, and the next write slot.
    always_comb begin
        old_raw  = (CNT_W + 1)'(r_ptr) + WMAX_EXT - (CNT_W + 1)'(r_held);
        old_wrap = (old_raw >= WMAX_EXT) ? (old_raw - WMAX_EXT) : old_raw;
        oldest   = old_wrap[IDX_W-1:0];
        ptr_next = (r_ptr == PTR_LAST) ? '0 : (r_ptr + 1'b1);
    end

    // Magnitude of the window sum for the unsigned divider.
    assign total_mag = r_total[SUM_W-1] ? SUM_W'(-r_total) : SUM_W'(r_total);

    grsd_div #(
        .N_W (SUM_W),
        .D_W (CNT_W)
    ) u_grsd_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (total_mag),
        .i_divisor  (r_held),
        .o_quotient (quotient),
        .o_stat     (div_stat)
    );

    // Signed average, truncated toward zero, and the rate-times-interval product.
    always_comb begin
        avg_mag = $signed({1'b0, quotient[RATE_W-1:0]});
        avg     = r_total[SUM_W-1] ? -avg_mag : avg_mag;
        dt_s    = $signed({1'b0, r_dt});
        mul_p   = WIDE_W'(r_adj) * WIDE_W'(dt_s);
    end

    // Threshold test and saturation of the new angle sum.
    always_comb begin
        hit = (r_sum >= LIM_POS) || (r_sum <= LIM_NEG);
        if (r_sum > ACC_MAX) begin
            sat_v = ACC_MAX;
        end else if (r_sum < ACC_MIN) begin
            sat_v = ACC_MIN;
        end else begin
            sat_v = r_sum;
        end
        out_free = !r_out_valid || o_out.ready;
    end

    // Sample ring: oldest entry read on acceptance, new sample written after.
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_rd <= r_ring[oldest];
        end
        if (r_state == ST_UPD) begin
            r_ring[r_ptr] <= r_sample;
        end
    end

    // Sequencer, window state, accumulator and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wsize     <= WSIZE_W'(1);
            r_bias      <= '0;
            r_ptr       <= '0;
            r_held      <= '0;
            r_total     <= '0;
            r_prev      <= '0;
            r_angle     <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            // A taken result beat frees the register unless a new one loads it now.
            if (o_out.valid && o_out.ready && !(r_state == ST_CHK && hit)) begin
                r_out_valid <= 1'b0;
            end

            // Register writes; a new window size empties the window.
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WINDOW_SIZE: begin
                        r_wsize <= i_cfg_data[WSIZE_W-1:0];
                        r_ptr   <= '0;
                        r_held  <= '0;
                        r_total <= '0;
                    end
                    CFG_RATE_BIAS: begin
                        r_bias <= $signed(i_cfg_data[BIAS_W-1:0]);
                    end
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (acc_in) begin
                        r_sample <= i_in.rate_z;
                        r_dt     <= i_in.time_ms - r_prev;
                        r_prev   <= i_in.time_ms;
                        r_evict  <= evict;
                        r_state  <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (r_evict) begin
                        r_total <= r_total - SUM_W'(r_rd) + SUM_W'(r_sample);
                    end else begin
                        r_total <= r_total + SUM_W'(r_sample);
                        r_held  <= r_held + 1'b1;
                    end
                    r_ptr       <= ptr_next;
                    r_div_start <= 1'b1;
                    r_state     <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        r_state <= ST_ADJ;
                    end
                end
                ST_ADJ: begin
                    r_adj   <= avg - ADJ_W'(r_bias);
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_step  <= mul_p;
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_sum   <= r_step + WIDE_W'(r_angle);
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    if (!hit) begin
                        r_angle <= sat_v[ANGLE_W-1:0];
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_pos   <= !r_sum[WIDE_W-1];
                        r_angle     <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.rotation_positive = r_out_pos;
endmodule

/* rtl/grsd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro rotation step detector checker
// Port-level assertions on the sample and result channels, bound to the top.
// ----------------------------------------------------------------------------
module grsd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_pos
);
    logic in_beat;

    assign in_beat = i_in_valid && i_in_ready;

    // The block is busy for the cycle after it takes a sample.
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !i_in_ready)
        else $error("sample accepted while previous sample still in work");

    // A waiting result beat holds its value until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_pos))
        else $error("result beat dropped or changed while stalled");

    // A newly taken sample cannot bring out a result before it has passed the update and divide states.
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(in_beat, 1) && !$past(in_beat, 2)
                               && !$past(in_beat, 3))
        else $error("result beat appeared too soon after a sample");

    // After reset the block is ready for a sample.
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("not ready after reset");
endmodule

bind gyro_rotation_step_detector_unit grsd_checker u_grsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_pos   (o_out.rotation_positive)
);

/* tb/tb_gyro_rotation_step_detector_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro rotation step detector testbench
// Drives Z rate samples with timestamps through the valid/ready channels and
// compares every quarter-turn beat with a local prediction of the moving
// average, bias removal, saturating integration and threshold. Directed tests
// cover reset defaults, timestamp wrap, bias and window extremes and output
// back-pressure; random phases then mix steady turns with noise.
// ----------------------------------------------------------------------------
module tb_gyro_rotation_step_detector_unit;
    import grsd_pkg::*;

    localparam int     HALF_PERIOD      = 2;
    localparam int     RESET_CYCLES     = 10;
    localparam int     WINDOW_DEPTH     = WINDOW_MAX_DEF;
    localparam int     SETTLE_CYCLES    = 40;
    localparam int     LONG_HOLD_CYCLES = 300;
    localparam int     WATCHDOG_LIMIT   = 2000;
    localparam int     RANDOM_PHASES    = 12;
    localparam int     PHASE_ITEMS      = 150;
    localparam longint ANGLE_MAX        = 64'sd549755813887;
    localparam longint ANGLE_MIN        = -ANGLE_MAX - 1;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    grsd_in_if  in_ch ();
    grsd_out_if out_ch ();

    gyro_rotation_step_detector_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Local copy of the detector state and its configuration.
    logic signed [RATE_W-1:0] win_samples [WINDOW_DEPTH];
    int                       win_ptr;
    int                       win_held;
    longint                   win_sum;
    logic [TIME_W-1:0]        last_time_ms;
    longint                   angle_acc;
    logic [WSIZE_W-1:0]       cfg_window;
    logic signed [BIAS_W-1:0] cfg_bias;

    // Directions of detected turns still owed by the block, oldest first.
    bit expected_turns[$];

    logic [TIME_W-1:0] stamp_now;
    int  fail_count    = 0;
    int  samples_taken = 0;
    int  turns_seen    = 0;
    int  reg_writes    = 0;
    int  idle_cycles   = 0;
    bit  src_idle_on   = 1'b1;
    bit  sink_stall_on = 1'b1;
    bit  hold_long     = 1'b0;

    function automatic void clear_window();
        win_ptr  = 0;
        win_held = 0;
        win_sum  = 0;
    endfunction

    function automatic void reset_prediction();
        clear_window();
        last_time_ms = '0;
        angle_acc    = 0;
        cfg_window   = WSIZE_W'(1);
        cfg_bias     = '0;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_WINDOW_SIZE: begin
                cfg_window = data[WSIZE_W-1:0];
                clear_window();
            end
            CFG_RATE_BIAS: begin
                cfg_bias = data[BIAS_W-1:0];
            end
            default: ;
        endcase
    endfunction

    // Feeds one sample into the window and the angle; returns 1 when a quarter
    // turn is detected, with its direction in positive.
    function automatic bit integrate_sample(input logic signed [RATE_W-1:0] rate,
                                            input logic [TIME_W-1:0] stamp,
                                            output bit positive);
        logic [TIME_W-1:0] dt_ms;
        int                eff_window;
        longint            avg_rate;
        longint            step_angle;
        longint            sum_angle;
        dt_ms        = stamp - last_time_ms;
        last_time_ms = stamp;
        if (cfg_window == 0)
            eff_window = 1;
        else if (int'(cfg_window) > WINDOW_DEPTH)
            eff_window = WINDOW_DEPTH;
        else
            eff_window = int'(cfg_window);

        // Slide the window: drop the oldest sample once it is full.
        if (win_held >= eff_window)
            win_sum -= win_samples[(win_ptr + WINDOW_DEPTH - win_held) % WINDOW_DEPTH];
        else
            win_held++;
        win_samples[win_ptr] = rate;
        win_sum += rate;
        win_ptr = (win_ptr + 1) % WINDOW_DEPTH;

        avg_rate   = win_sum / win_held;
        step_angle = (avg_rate - cfg_bias) * longint'(dt_ms);

        sum_angle = angle_acc + step_angle;
        if (sum_angle > ANGLE_MAX)
            sum_angle = ANGLE_MAX;
        if (sum_angle < ANGLE_MIN)
            sum_angle = ANGLE_MIN;
        angle_acc = sum_angle;

        positive = 1'b0;
        if (sum_angle >= ANGLE_LIMIT || sum_angle <= -ANGLE_LIMIT) begin
            positive  = (sum_angle > 0);
            angle_acc = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic signed [RATE_W-1:0] sat_rate(input int value);
        if (value > 32767)
            return 16'sh7FFF;
        if (value < -32768)
            return 16'sh8000;
        return value[RATE_W-1:0];
    endfunction

    // Predict on every accepted sample beat and check every result beat.
    always @(posedge i_clk) begin : beat_monitor
        bit positive;
        bit want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                samples_taken++;
                if (integrate_sample(in_ch.rate_z, in_ch.time_ms, positive))
                    expected_turns.push_back(positive);
            end
            if (out_ch.valid && out_ch.ready) begin
                turns_seen++;
                if (expected_turns.size() == 0) begin
                    $error("rotation_positive: expected no beat, actual %0b",
                           out_ch.rotation_positive);
                    fail_count++;
                end else begin
                    want = expected_turns.pop_front();
                    if (out_ch.rotation_positive !== want) begin
                        $error("rotation_positive: expected %0b, actual %0b",
                               want, out_ch.rotation_positive);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Ends the run if neither channel nor the register port moves for too long.
    always @(posedge i_clk) begin : watchdog
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d quiet cycles", idle_cycles);
            $display("gyro_rotation_step_detector_unit verification failed");
            $finish;
        end
    end

    // Result receiver: random stall bursts, or one long hold-off on request.
    initial begin : result_sink
        forever begin
            if (hold_long) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                hold_long = 1'b0;
            end else if (sink_stall_on && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Offers one sample beat, after an optional gap, and returns once it is
    // accepted; valid is left high for the caller.
    task automatic send_sample(input logic signed [RATE_W-1:0] rate,
                               input logic [TIME_W-1:0] stamp);
        int gap;
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.rate_z  <= rate;
        in_ch.time_ms <= stamp;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_after(input logic signed [RATE_W-1:0] rate,
                              input int unsigned dt_ms);
        stamp_now = stamp_now + dt_ms;
        send_sample(rate, stamp_now);
    endtask

    // Stops offering and lets every owed turn arrive, then lets any sample
    // still in flight that causes no turn finish.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_turns.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_reg_write(idx, data);
        reg_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // The upper data bits are random so that only the size field may matter.
    task automatic set_window(input logic [WSIZE_W-1:0] size);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        data[WSIZE_W-1:0] = size;
        write_reg(CFG_WINDOW_SIZE, data);
    endtask

    // Reset defaults: window of one, no bias, first interval measured from zero.
    task automatic test_reset_defaults();
        stamp_now = '0;
        send_after(16000, 100);
        send_after(-32768, 100);
        send_after(32767, 0);
        send_after(100, 100);
    endtask

    // Huge intervals saturate the angle; the counter wrap gives a short interval.
    task automatic test_timestamp_wrap();
        stamp_now = 32'hFFFF_FFF0;
        send_sample(32767, stamp_now);
        send_after(-32768, 32'h20);
        send_after(-32768, 10);
        send_after(-1, 32'h7FFF_FFE6);
    endtask

    // Bias at both extremes, giving the widest corrected rate either way.
    task automatic test_bias_extremes();
        wait_idle();
        write_reg(CFG_RATE_BIAS, 16'h8000);
        send_after(32767, 30);
        wait_idle();
        write_reg(CFG_RATE_BIAS, 16'h7FFF);
        send_after(-32768, 30);
        send_after(32767, 1000);
    endtask

    // Averaging with truncation, window sliding, a bias change that keeps the
    // window, and sizes of zero, above the depth and at the depth.
    task automatic test_window_sizes();
        wait_idle();
        set_window(4);
        write_reg(CFG_RATE_BIAS, 16'h0000);
        send_after(-3, 1);
        send_after(-2, 1);
        send_after(32767, 40);
        send_after(32767, 40);
        send_after(32767, 40);
        send_after(32767, 40);
        send_after(-32768, 40);
        wait_idle();
        write_reg(CFG_RATE_BIAS, 16'd100);
        send_after(5000, 60);
        wait_idle();
        set_window(0);
        send_after(20000, 70);
        wait_idle();
        set_window(127);
        send_after(-20000, 70);
        send_after(-20000, 1);
        wait_idle();
        set_window(64);
        send_after(100, 10);
    endtask

    // The receiver holds off while the sender offers back to back, each sample
    // causing a turn, so the block fills and stalls its input.
    task automatic test_backpressure();
        int i;
        wait_idle();
        set_window(1);
        write_reg(CFG_RATE_BIAS, 16'h0000);
        src_idle_on = 1'b0;
        hold_long   = 1'b1;
        for (i = 0; i < 24; i++)
            send_after(RATE_W'((i % 2) ? -32768 : 32767), 50);
        src_idle_on = 1'b1;
        wait_idle();
    endtask

    // The sender stops after each burst until every owed turn has come back.
    task automatic test_sender_pause();
        int burst;
        int i;
        int mag;
        for (burst = 0; burst < 3; burst++) begin
            for (i = 0; i < 10; i++) begin
                mag = $urandom_range(10000, 32767);
                send_after(sat_rate($urandom_range(0, 1) ? mag : -mag),
                           $urandom_range(20, 80));
            end
            in_ch.valid <= 1'b0;
            while (expected_turns.size() != 0) @(posedge i_clk);
        end
    endtask

    // A sample with any rate and an interval that is short, long, or a jump to
    // an arbitrary timestamp.
    task automatic send_noise();
        logic signed [RATE_W-1:0] rate;
        int                       pick;
        rate = RATE_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            send_after(rate, $urandom_range(0, 5));
        end else if (pick < 9) begin
            send_after(rate, $urandom_range(0, 1000));
        end else begin
            stamp_now = $urandom;
            send_sample(rate, stamp_now);
        end
    endtask

    // Random phases: a fresh setting each time, then mostly steady turns with
    // a little jitter around the bias, mixed with noise samples.
    task automatic test_random_phases();
        int                       phase;
        int                       sent;
        int                       run_len;
        int                       base;
        int                       pick;
        logic [WSIZE_W-1:0]       size;
        logic signed [BIAS_W-1:0] bias;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            // The closing phases run without any idling on either side.
            if (phase >= RANDOM_PHASES - 2) begin
                src_idle_on   = 1'b0;
                sink_stall_on = 1'b0;
            end
            // Every third phase changes only the bias and keeps the window.
            if (phase % 3 != 2) begin
                pick = $urandom_range(0, 5);
                case (pick)
                    0:       size = WSIZE_W'(0);
                    1:       size = WSIZE_W'(1);
                    2:       size = WSIZE_W'($urandom_range(2, 8));
                    3:       size = WSIZE_W'($urandom_range(9, 63));
                    4:       size = WSIZE_W'(64);
                    default: size = WSIZE_W'($urandom_range(65, 127));
                endcase
                set_window(size);
            end
            pick = $urandom_range(0, 3);
            case (pick)
                0, 1:    bias = BIAS_W'(int'($urandom_range(0, 400)) - 200);
                2:       bias = BIAS_W'($urandom);
                default: bias = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            endcase
            write_reg(CFG_RATE_BIAS, bias);

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 4) != 0) begin
                    run_len = $urandom_range(3, 15);
                    base    = int'(cfg_bias) + ($urandom_range(0, 1) ? 1 : -1)
                              * int'($urandom_range(500, 20000));
                    repeat (run_len)
                        send_after(sat_rate(base + int'($urandom_range(0, 128)) - 64),
                                   $urandom_range(5, 60));
                    sent += run_len;
                end else begin
                    send_noise();
                    sent++;
                end
            end
        end
    endtask

    initial begin : main_sequence
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.rate_z  <= '0;
        in_ch.time_ms <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_WINDOW_SIZE;
        i_cfg_data    <= '0;
        reset_prediction();
        stamp_now = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_timestamp_wrap();
        test_bias_extremes();
        test_window_sizes();
        test_backpressure();
        test_sender_pause();
        test_random_phases();
        wait_idle();

        $display("Run covered %0d samples, %0d turn beats and %0d register writes:",
                 samples_taken, turns_seen, reg_writes);
        $display("window sizes 0 to 127, bias extremes, timestamp wrap, saturation, stalls.");
        if (fail_count == 0) begin
            $display("gyro_rotation_step_detector_unit verification clean");
        end else begin
            $display("gyro_rotation_step_detector_unit verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/grsd_pkg.sv
rtl/grsd_in_if.sv
rtl/grsd_out_if.sv
rtl/grsd_div.sv
rtl/gyro_rotation_step_detector_unit.sv
rtl/grsd_checker.sv
tb/tb_gyro_rotation_step_detector_unit.sv
